[hw/rtl/mpq_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and state codes of the minimum priority queue.
package mpq_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int ENTRY_W = DATA_W + PRIO_W;
	localparam int COUNT_OUT_W = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_DONE = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SH_RD,
		ST_SH_WR,
		ST_FIN
	} state_t;

	typedef struct packed {
		op_t op;
		logic signed [DATA_W-1:0] item_data;
		logic signed [PRIO_W-1:0] item_priority;
	} in_t;

	typedef struct packed {
		status_t status;
		logic signed [DATA_W-1:0] out_data;
		logic signed [PRIO_W-1:0] out_priority;
		logic [COUNT_OUT_W-1:0] entry_count;
	} out_t;

endpackage

[hw/rtl/mpq_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/mpq_core.sv]
`timescale 1ns / 1ps
// Sequencer with the shared priority comparator: insert, minimum scan and compaction.
module mpq_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  mpq_pkg::in_t                    item,
	output logic                            idle,
	output logic                            res_valid,
	input  logic                            res_ready,
	output mpq_pkg::out_t                   res,
	output logic                            ram_we,
	output logic [mpq_pkg::IDX_W-1:0]       ram_waddr,
	output logic [mpq_pkg::ENTRY_W-1:0]     ram_wdata,
	output logic [mpq_pkg::IDX_W-1:0]       ram_raddr,
	input  logic [mpq_pkg::ENTRY_W-1:0]     ram_rdata
);

	mpq_pkg::state_t state_q, state_d;
	logic [mpq_pkg::CNT_W-1:0] count_q;
	logic [mpq_pkg::CNT_W-1:0] scan_q;
	logic cmp_v_q;
	logic [mpq_pkg::IDX_W-1:0] cmp_idx_q;
	logic [mpq_pkg::IDX_W-1:0] sh_q;
	logic signed [mpq_pkg::PRIO_W-1:0] best_pri_q;
	logic signed [mpq_pkg::DATA_W-1:0] best_data_q;
	mpq_pkg::out_t res_q;

	logic signed [mpq_pkg::PRIO_W-1:0] rd_pri;
	logic signed [mpq_pkg::DATA_W-1:0] rd_data;
	logic issue, take, scan_done, shift_more, full, empty;
	logic [mpq_pkg::CNT_W-1:0] count_dec;

	assign rd_pri = ram_rdata[mpq_pkg::ENTRY_W-1:mpq_pkg::DATA_W];
	assign rd_data = ram_rdata[mpq_pkg::DATA_W-1:0];
	assign full = (count_q >= mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
	assign empty = (count_q == '0);
	assign count_dec = count_q - mpq_pkg::CNT_W'(1);
	assign issue = (state_q == mpq_pkg::ST_SCAN) && (scan_q < count_q);
	assign take = cmp_v_q && ((cmp_idx_q == '0) || (rd_pri < best_pri_q));
	assign scan_done = (state_q == mpq_pkg::ST_SCAN) && (scan_q == count_q) && !cmp_v_q;
	// The count drops when the scan ends, so one compare serves both the first
	// and every later shift decision.
	assign shift_more = (mpq_pkg::CNT_W'(sh_q) + mpq_pkg::CNT_W'(1)) < count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpq_pkg::ST_IDLE: begin
				if (start) begin
					if (item.op == mpq_pkg::OP_REMOVE && !empty) begin
						state_d = mpq_pkg::ST_SCAN;
					end else begin
						state_d = mpq_pkg::ST_FIN;
					end
				end
			end
			mpq_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = shift_more ? mpq_pkg::ST_SH_RD : mpq_pkg::ST_FIN;
				end
			end
			mpq_pkg::ST_SH_RD: begin
				state_d = mpq_pkg::ST_SH_WR;
			end
			mpq_pkg::ST_SH_WR: begin
				state_d = shift_more ? mpq_pkg::ST_SH_RD : mpq_pkg::ST_FIN;
			end
			mpq_pkg::ST_FIN: begin
				if (res_ready) begin
					state_d = mpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		idle = 1'b0;
		res_valid = 1'b0;
		ram_we = 1'b0;
		ram_waddr = count_q[mpq_pkg::IDX_W-1:0];
		ram_wdata = {item.item_priority, item.item_data};
		ram_raddr = scan_q[mpq_pkg::IDX_W-1:0];
		unique case (state_q)
			mpq_pkg::ST_IDLE: begin
				idle = 1'b1;
				ram_we = start && (item.op == mpq_pkg::OP_INSERT) && !full;
			end
			mpq_pkg::ST_SCAN: begin
			end
			mpq_pkg::ST_SH_RD: begin
				ram_raddr = sh_q + mpq_pkg::IDX_W'(1);
			end
			mpq_pkg::ST_SH_WR: begin
				ram_we = 1'b1;
				ram_waddr = sh_q;
				ram_wdata = ram_rdata;
			end
			mpq_pkg::ST_FIN: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpq_pkg::ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			cmp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mpq_pkg::ST_IDLE && start) begin
				scan_q <= '0;
				cmp_v_q <= 1'b0;
				if (item.op == mpq_pkg::OP_INSERT && !full) begin
					count_q <= count_q + mpq_pkg::CNT_W'(1);
				end
			end
			if (state_q == mpq_pkg::ST_SCAN) begin
				if (issue) begin
					scan_q <= scan_q + mpq_pkg::CNT_W'(1);
				end
				cmp_v_q <= issue;
			end
			if (scan_done) begin
				count_q <= count_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpq_pkg::ST_IDLE && start) begin
			res_q.out_data <= '0;
			res_q.out_priority <= '0;
			if (item.op == mpq_pkg::OP_INSERT) begin
				if (full) begin
					res_q.status <= mpq_pkg::STATUS_OVERFLOW;
					res_q.entry_count <= mpq_pkg::COUNT_OUT_W'(count_q);
				end else begin
					res_q.status <= mpq_pkg::STATUS_DONE;
					res_q.entry_count <= mpq_pkg::COUNT_OUT_W'(count_q + mpq_pkg::CNT_W'(1));
				end
			end else begin
				res_q.status <= mpq_pkg::STATUS_UNDERFLOW;
				res_q.entry_count <= mpq_pkg::COUNT_OUT_W'(count_q);
			end
		end
		cmp_idx_q <= scan_q[mpq_pkg::IDX_W-1:0];
		if (take) begin
			sh_q <= cmp_idx_q;
			best_pri_q <= rd_pri;
			best_data_q <= rd_data;
		end
		if (scan_done) begin
			res_q.status <= mpq_pkg::STATUS_DONE;
			res_q.out_data <= best_data_q;
			res_q.out_priority <= best_pri_q;
			res_q.entry_count <= mpq_pkg::COUNT_OUT_W'(count_dec);
		end
		if (state_q == mpq_pkg::ST_SH_WR) begin
			sh_q <= sh_q + mpq_pkg::IDX_W'(1);
		end
	end

endmodule

[hw/rtl/min_priority_queue.sv]
`timescale 1ns / 1ps
// Top level of the minimum priority queue: entry store, sequencer and output register.
//
// Words enter on in_valid/in_ready with an in_item carrying op, item_data and
// item_priority. Each word yields exactly one result word on out_valid/out_ready.
// An insert appends the entry behind those already stored, or reports overflow
// when all DEPTH slots are full. A remove returns the entry with the smallest
// signed priority, the earliest one on a tie, and moves later entries up one
// slot; on an empty queue it reports underflow.
// One word is in work at a time and in_ready is low until it is finished.
// A remove scans all n stored entries and then moves the n - 1 - k entries behind
// the chosen slot k up one place: the single comparator reads one slot per cycle
// through the one read port of the entry RAM, and each compaction move is a read
// followed by a write. The result sits in an output register, so the next word is
// accepted while a result still waits; a stalled receiver holds the sequencer only
// once a second result is ready. Reset empties the queue; no clearing pass is needed.
module min_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mpq_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output mpq_pkg::out_t out_item
);

	logic core_idle;
	logic res_valid, res_ready;
	mpq_pkg::out_t res;
	logic ram_we;
	logic [mpq_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
	logic [mpq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic out_valid_q;
	mpq_pkg::out_t out_q;

	assign in_ready = core_idle;
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	mpq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.item      (in_item),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	mpq_ram #(
		.WIDTH (mpq_pkg::ENTRY_W),
		.DEPTH (mpq_pkg::DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

endmodule
